// ----- src/gs5_pkg.sv -----
// ----------------------------------------------------------------------------
// gs5_pkg
// shared constants, codes and the binomial tap helper of the 5x5 gaussian
// stream filter
// ----------------------------------------------------------------------------
package gs5_pkg;

  // default maximum frame sizes; the width also sizes the line memory
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // window geometry
  localparam int RADIUS = 2;
  localparam int TAPS   = 5;
  localparam int LINES  = 4;
  localparam int MIN_DIM = 5;

  // field widths
  localparam int PIX_W     = 8;
  localparam int COLSUM_W  = 12;
  localparam int WSUM_W    = 16;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  // register reset values
  localparam int CFG_WIDTH_RST  = 640;
  localparam int CFG_HEIGHT_RST = 480;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // binomial taps
  localparam logic [WSUM_W-1:0] TAP_W0 = 16'd1;
  localparam logic [WSUM_W-1:0] TAP_W1 = 16'd4;
  localparam logic [WSUM_W-1:0] TAP_W2 = 16'd6;

  function automatic logic [WSUM_W-1:0] wsum5(
    input logic [WSUM_W-1:0] a,
    input logic [WSUM_W-1:0] b,
    input logic [WSUM_W-1:0] c,
    input logic [WSUM_W-1:0] d,
    input logic [WSUM_W-1:0] e
  );
    wsum5 = a * TAP_W0 + b * TAP_W1 + c * TAP_W2 + d * TAP_W1 + e * TAP_W0;
  endfunction

endpackage

// ----- src/gaussian_5x5_stream_filter.sv -----
// ----------------------------------------------------------------------------
// gaussian_5x5_stream_filter
// 5x5 binomial blur over a raster pixel stream, border pixels passed through
// throughput: one item per clock while the output is not stalled; a result passes
//   the sum stage and then the output register after the transfer that releases
//   it (the column is prefetched from the line memory before that transfer)
// reset: synchronous; clears positions, pending count, window and valids and
//   loads 640x480; the line memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module gaussian_5x5_stream_filter #(
  parameter int MAX_WIDTH  = gs5_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gs5_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gs5_pkg::PIX_W-1:0]         s_tdata,   // pixel_in
  input  logic                              s_tuser,   // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gs5_pkg::PIX_W-1:0]         m_tdata,   // pixel_out
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gs5_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gs5_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(2 * MAX_WIDTH + 3);
  localparam int LINES = gs5_pkg::LINES;
  localparam int RST_W = (gs5_pkg::CFG_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : gs5_pkg::CFG_WIDTH_RST;
  localparam int RST_H = (gs5_pkg::CFG_HEIGHT_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : gs5_pkg::CFG_HEIGHT_RST;

  // frame size minus one
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [CW-1:0] wm1_cfg;
  logic [RW-1:0] hm1_cfg;

  logic [CW-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [RW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [PW-1:0] pending, pending_next;

  // window as column sums plus the center row
  logic [gs5_pkg::COLSUM_W-1:0] cs [gs5_pkg::TAPS];
  logic [gs5_pkg::PIX_W-1:0]    mid3, mid4;

  logic                         s1_valid, s1_sum, s1_last;
  logic [gs5_pkg::PIX_W-1:0]    s1_val;
  logic                         out_valid, out_last;
  logic [gs5_pkg::PIX_W-1:0]    out_pix;

  logic [gs5_pkg::PIX_W-1:0]    rda [LINES];
  logic [gs5_pkg::PIX_W-1:0]    rdb [LINES];
  logic [gs5_pkg::PIX_W-1:0]    wd  [LINES];
  logic [1:0]                   fq, fq_next;
  logic                         fbyp;
  logic [gs5_pkg::PIX_W-1:0]    fbyp_val;
  logic [CW-1:0]                faddr;

  logic cfg_wr, pix_acc, fl_acc, fl_fire, pix_emit, emit, border, last;
  logic out_free, s1_ready;
  logic [PW-1:0] w_p, w2_p, dly, fd, fm;
  logic [gs5_pkg::COLSUM_W-1:0] colsum;
  logic [gs5_pkg::WSUM_W-1:0]   win_sum;
  logic [gs5_pkg::PIX_W-1:0]    fl_val;
  logic [gs5_pkg::IMG_W_W-1:0]  raw_w;
  logic [gs5_pkg::IMG_H_W-1:0]  raw_h;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_free = !out_valid || m_tready;
  assign s1_ready = !s1_valid || out_free;
  assign s_tready = s1_ready;

  assign pix_acc = s_tvalid && s_tready && (s_tuser == gs5_pkg::KIND_PIXEL);
  assign fl_acc  = s_tvalid && s_tready && (s_tuser == gs5_pkg::KIND_FLUSH);
  assign fl_fire = fl_acc && (in_row == '0) && (in_col == '0) && (pending != '0);

  assign w_p  = PW'(wm1) + PW'(1);
  assign w2_p = w_p + w_p;
  assign dly  = w2_p + PW'(2);
  assign pix_emit = (pending >= dly);
  assign emit = (pix_acc && pix_emit) || fl_fire;

  assign border = (out_row < RW'(gs5_pkg::RADIUS)) ||
                  (out_row > hm1 - RW'(gs5_pkg::RADIUS)) ||
                  (out_col < CW'(gs5_pkg::RADIUS)) ||
                  (out_col > wm1 - CW'(gs5_pkg::RADIUS));
  assign last = (out_row == hm1) && (out_col == wm1);

  // clamp of register writes
  always_comb begin
    raw_w = cfg_data[gs5_pkg::IMG_W_W-1:0];
    raw_h = cfg_data[gs5_pkg::IMG_H_W-1:0];
    if (int'(raw_w) < gs5_pkg::MIN_DIM) begin
      wm1_cfg = CW'(gs5_pkg::MIN_DIM - 1);
    end else if (int'(raw_w) > MAX_WIDTH) begin
      wm1_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      wm1_cfg = CW'(int'(raw_w) - 1);
    end
    if (int'(raw_h) < gs5_pkg::MIN_DIM) begin
      hm1_cfg = RW'(gs5_pkg::MIN_DIM - 1);
    end else if (int'(raw_h) > MAX_HEIGHT) begin
      hm1_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1_cfg = RW'(int'(raw_h) - 1);
    end
  end

  // positions and pending count
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pending_next = pending;
    if (cfg_wr) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
      pending_next = '0;
    end else begin
      if (pix_acc) begin
        if (in_col == wm1) begin
          in_col_next = '0;
          in_row_next = (in_row == hm1) ? '0 : in_row + RW'(1);
        end else begin
          in_col_next = in_col + CW'(1);
        end
        pending_next = pix_emit ? pending : pending + PW'(1);
      end
      if (fl_fire) begin
        pending_next = pending - PW'(1);
      end
      if (emit) begin
        if (out_col == wm1) begin
          out_col_next = '0;
          out_row_next = (out_row == hm1) ? '0 : out_row + RW'(1);
        end else begin
          out_col_next = out_col + CW'(1);
        end
      end
    end
  end

  // flush tap: line and column of the oldest pending pixel
  always_comb begin
    fd = pending_next - PW'(1);
    if (fd >= w2_p) begin
      fq_next = 2'd2;
      fm = fd - w2_p;
    end else if (fd >= w_p) begin
      fq_next = 2'd1;
      fm = fd - w_p;
    end else begin
      fq_next = 2'd0;
      fm = fd;
    end
    faddr = wm1 - CW'(fm);
  end

  assign wd[0] = s_tdata;
  assign wd[1] = rda[0];
  assign wd[2] = rda[1];
  assign wd[3] = rda[2];

  // line memory, one bank per line, prefetch of the next column
  for (genvar k = 0; k < LINES; k++) begin : g_line
    logic [gs5_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [gs5_pkg::PIX_W-1:0] rd_a, rd_b;
    always_ff @(posedge clk) begin
      if (pix_acc) begin
        line_mem[in_col] <= wd[k];
      end
      rd_a <= line_mem[in_col_next];
      rd_b <= line_mem[faddr];
    end
    assign rda[k] = rd_a;
    assign rdb[k] = rd_b;
  end

  assign colsum = gs5_pkg::COLSUM_W'(gs5_pkg::wsum5(
                    16'(rda[3]), 16'(rda[2]), 16'(rda[1]), 16'(rda[0]), 16'(s_tdata)));
  assign win_sum = gs5_pkg::wsum5(16'(cs[0]), 16'(cs[1]), 16'(cs[2]), 16'(cs[3]),
                                  16'(cs[4]));
  assign fl_val = fbyp ? fbyp_val : rdb[fq];

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1       <= CW'(RST_W - 1);
      hm1       <= RW'(RST_H - 1);
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      pending   <= '0;
      for (int i = 0; i < gs5_pkg::TAPS; i++) begin
        cs[i] <= '0;
      end
      mid3      <= '0;
      mid4      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fq        <= '0;
      fbyp      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          gs5_pkg::CFG_IMAGE_WIDTH:  wm1 <= wm1_cfg;
          gs5_pkg::CFG_IMAGE_HEIGHT: hm1 <= hm1_cfg;
          default: ;
        endcase
      end
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      pending <= pending_next;
      fq      <= fq_next;
      fbyp    <= pix_acc && (faddr == in_col);
      if (pix_acc) begin
        for (int i = 0; i < gs5_pkg::TAPS - 1; i++) begin
          cs[i] <= cs[i+1];
        end
        cs[gs5_pkg::TAPS-1] <= colsum;
        mid3 <= mid4;
        mid4 <= rda[1];
      end
      if (s1_ready) begin
        s1_valid <= emit;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    fbyp_val <= wd[fq_next];
    if (s1_ready && emit) begin
      s1_sum  <= pix_acc && !border;
      s1_val  <= pix_acc ? mid3 : fl_val;
      s1_last <= last;
    end
    if (out_free && s1_valid) begin
      out_pix  <= s1_sum ? win_sum[gs5_pkg::WSUM_W-1 -: gs5_pkg::PIX_W] : s1_val;
      out_last <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pix;
  assign m_tlast  = out_last;

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= dly)
    else $error("pending count above the window delay");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    in_col <= wm1 && out_col <= wm1 && in_row <= hm1 && out_row <= hm1)
    else $error("frame position outside the frame");

  a_emit_stage: assert property (@(posedge clk) disable iff (rst)
    pix_acc && pix_emit |=> s1_valid)
    else $error("released pixel lost before the output register");
`endif

endmodule

// ----- verif/tb_gaussian_5x5_stream_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_5x5_stream_filter
// self-checking testbench of the 5x5 gaussian stream filter: a behavioral
// line-buffer and window model predicts every filtered pixel and frame marker;
// reset size, minimum frames with extreme pixels, clamped sizes, random
// frames under four idling patterns and a long output hold-off are run in
// turn, and every output transfer is compared in order
// ----------------------------------------------------------------------------
module tb_gaussian_5x5_stream_filter;
  import gs5_pkg::*;

  localparam int MAXW        = MAX_WIDTH_DEF;
  localparam int MAXH        = MAX_HEIGHT_DEF;
  localparam int DRAIN_PAD   = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int LOG_LIMIT   = 100;
  localparam logic [TAPS-1:0][3:0] BINOM = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eof;
  } blur_pixel_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIX_W-1:0]       s_tdata = '0;
  logic                   s_tuser = KIND_PIXEL;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [PIX_W-1:0]       m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // blur model state
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  logic [PIX_W-1:0]   line_mem [LINES][MAXW];
  logic [PIX_W-1:0]   win [TAPS][TAPS];
  int unsigned        in_col, in_row, out_col, out_row, backlog;
  blur_pixel_t        blur_expected [$];

  int   fail_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;

  always #2 clk = ~clk;

  gaussian_5x5_stream_filter #(
    .MAX_WIDTH  (MAXW),
    .MAX_HEIGHT (MAXH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    backlog = 0;
  endfunction

  function automatic void reset_model();
    width_reg = IMG_W_W'(CFG_WIDTH_RST);
    height_reg = IMG_H_W'(CFG_HEIGHT_RST);
    for (int i = 0; i < LINES; i++)
      for (int j = 0; j < MAXW; j++)
        line_mem[i][j] = '0;
    for (int i = 0; i < TAPS; i++)
      for (int j = 0; j < TAPS; j++)
        win[i][j] = '0;
    restart_frame();
  endfunction

  function automatic void model_config(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_IMAGE_WIDTH) width_reg = val[IMG_W_W-1:0];
    else height_reg = val[IMG_H_W-1:0];
    restart_frame();
  endfunction

  function automatic void push_result(input logic [PIX_W-1:0] value, input int unsigned w,
                                      input int unsigned h);
    blur_pixel_t r;
    r.pixel = value;
    r.eof = (out_row == h - 1) && (out_col == w - 1);
    blur_expected.push_back(r);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endfunction

  function automatic void model_item(input logic kind, input logic [PIX_W-1:0] px);
    int unsigned      w, h, col, d, q, m, newest, sum;
    logic [PIX_W-1:0] column [TAPS];
    w = active_width();
    h = active_height();
    col = in_col % w;
    if (kind == KIND_FLUSH) begin
      // only drains at a frame boundary
      if (in_row != 0 || in_col != 0 || backlog == 0) return;
      d = backlog - 1;
      q = d / w;
      m = d % w;
      if (q >= LINES) q = LINES - 1;
      newest = (col + w - 1) % w;
      push_result(line_mem[q][(newest + w - m) % w], w, h);
      backlog--;
      return;
    end
    column[0] = line_mem[3][col];
    column[1] = line_mem[2][col];
    column[2] = line_mem[1][col];
    column[3] = line_mem[0][col];
    column[4] = px;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS - 1; j++)
        win[i][j] = win[i][j+1];
      win[i][TAPS-1] = column[i];
    end
    line_mem[3][col] = column[1];
    line_mem[2][col] = column[2];
    line_mem[1][col] = column[3];
    line_mem[0][col] = px;
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    backlog++;
    if (backlog > 2 * w + 2) begin
      if (out_row < RADIUS || out_row >= h - RADIUS ||
          out_col < RADIUS || out_col >= w - RADIUS) begin
        push_result(win[RADIUS][RADIUS], w, h);
      end else begin
        sum = 0;
        for (int i = 0; i < TAPS; i++)
          for (int j = 0; j < TAPS; j++)
            sum += win[i][j] * BINOM[i] * BINOM[j];
        push_result(PIX_W'(sum >> 8), w, h);
      end
      backlog--;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 65;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 65;
      end
      default: begin
        gap_pct = 8;
        stall_pct = 8;
      end
    endcase
  endfunction

  // starts at a falling edge, returns at the rising edge of the transfer
  task automatic send_item(input logic kind, input logic [PIX_W-1:0] px);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_item(kind, px);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic drain_frame();
    while (backlog != 0 && in_col == 0 && in_row == 0)
      send_item(KIND_FLUSH, PIX_W'($urandom));
    send_item(KIND_FLUSH, PIX_W'($urandom));
  endtask

  task automatic send_frames(input int unsigned count);
    for (int unsigned n = 0; n < count * active_width() * active_height(); n++)
      send_item(KIND_PIXEL, rand_pixel());
  endtask

  task automatic test_reset_size();
    set_idling(IDLE_NONE);
    // 640 wide after reset: the first row stays inside the line delay
    repeat (48) send_item(KIND_PIXEL, rand_pixel());
    send_item(KIND_FLUSH, 8'h3c);
    wait_drained();
  endtask

  task automatic test_border_and_extremes();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(MIN_DIM));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
    send_item(KIND_FLUSH, 8'h5a);
    // full-scale frame with a dark center, flush in mid-frame
    for (int n = 0; n < MIN_DIM * MIN_DIM; n++) begin
      send_item(KIND_PIXEL, (n == 12) ? 8'h00 : 8'hff);
      if (n == 10) send_item(KIND_FLUSH, 8'ha5);
    end
    // next frame starts before the tail is flushed
    for (int n = 0; n < 2 * MIN_DIM + 2; n++)
      send_item(KIND_PIXEL, (n % 2 == 0) ? 8'h00 : 8'hff);
    send_item(KIND_FLUSH, 8'hff);
    send_item(KIND_FLUSH, 8'h00);
    wait_drained();
  endtask

  task automatic test_size_clamp();
    write_reg(CFG_IMAGE_WIDTH, 13'h1003);
    write_reg(CFG_IMAGE_HEIGHT, 13'h0000);
    send_frames(2);
    drain_frame();
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 13'h1fff);
    write_reg(CFG_IMAGE_WIDTH, 13'h0000);
    repeat (30) send_item(KIND_PIXEL, rand_pixel());
    wait_drained();
  endtask

  task automatic test_full_width();
    set_idling(IDLE_BOTH);
    write_reg(CFG_IMAGE_WIDTH, 13'h07ff);
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
    // clamped to full width: the start of the frame stays inside the line delay
    repeat (40) send_item(KIND_PIXEL, rand_pixel());
    drain_frame();
    wait_drained();
  endtask

  task automatic test_random_frames(input idle_mode_t mode, input int target);
    int          sent;
    int unsigned total;
    set_idling(mode);
    sent = 0;
    while (sent < target) begin
      write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(12, MIN_DIM)));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(9, MIN_DIM)));
      total = $urandom_range(2, 1) * active_width() * active_height();
      // broken ending: stop somewhere inside an extra frame
      if ($urandom_range(99) < 15)
        total += $urandom_range(active_width() * active_height() - 1, 1);
      for (int unsigned n = 0; n < total; n++) begin
        if ($urandom_range(99) < 6) send_item(KIND_FLUSH, PIX_W'($urandom));
        send_item(KIND_PIXEL, rand_pixel());
        sent++;
      end
      drain_frame();
      wait_drained();
    end
  endtask

  task automatic test_output_hold();
    set_idling(IDLE_NONE);
    write_reg(CFG_IMAGE_WIDTH, 13'd8);
    write_reg(CFG_IMAGE_HEIGHT, 13'd6);
    @(posedge clk);
    hold_request = 1'b1;
    send_frames(1);
    drain_frame();
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    blur_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (blur_expected.size() == 0) begin
        // keep the log short
        if (fail_count < LOG_LIMIT)
          $display("%0t: unexpected transfer, expected none, got pixel %0d last %0b",
                   $time, m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = blur_expected.pop_front();
        if (m_tdata !== want.pixel || m_tlast !== want.eof) begin
          if (fail_count < LOG_LIMIT)
            $display("%0t: mismatch, expected pixel %0d last %0b, got pixel %0d last %0b",
                     $time, want.pixel, want.eof, m_tdata, m_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_size();
    test_border_and_extremes();
    test_size_clamp();
    test_full_width();
    test_random_frames(IDLE_NONE, 40);
    test_random_frames(IDLE_SENDER, 40);
    test_random_frames(IDLE_RECEIVER, 40);
    test_random_frames(IDLE_BOTH, 40);
    test_output_hold();
    if (fail_count == 0 && blur_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
